// File: sv/packstream_token_encoder_unit_defines.svh
`ifndef PACKSTREAM_TOKEN_ENCODER_UNIT_DEFINES_SVH
`define PACKSTREAM_TOKEN_ENCODER_UNIT_DEFINES_SVH

// property checked at every rising edge, ignored while reset is high
`define PSTE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pste checker: property failed");

// property checked at every rising edge, reset included
`define PSTE_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("pste checker: property failed around reset");

`endif

// File: sv/pste_pkg.sv
`timescale 1ns / 1ps

package pste_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned GROUP_BYTES = 9;
   localparam int unsigned GROUP_W = 8 * GROUP_BYTES;
   localparam int unsigned LEN_W = 4;

   localparam logic [63:0] MAX_STRING_BYTES = 64'd16777216;
   localparam logic [63:0] MAX_ELEMENTS = 64'd1048576;
   localparam logic [63:0] MAX_STRUCT_FIELDS = 64'd15;
   localparam logic [31:0] RESET_CAPACITY = 32'd65536;

   localparam logic [7:0] MK_NULL = 8'hC0;
   localparam logic [7:0] MK_FLOAT = 8'hC1;
   localparam logic [7:0] MK_FALSE = 8'hC2;
   localparam logic [7:0] MK_TRUE = 8'hC3;
   localparam logic [7:0] MK_INT8 = 8'hC8;
   localparam logic [7:0] MK_INT16 = 8'hC9;
   localparam logic [7:0] MK_INT32 = 8'hCA;
   localparam logic [7:0] MK_INT64 = 8'hCB;
   localparam logic [7:0] MK_STRING_TINY = 8'h80;
   localparam logic [7:0] MK_LIST_TINY = 8'h90;
   localparam logic [7:0] MK_DICT_TINY = 8'hA0;
   localparam logic [7:0] MK_STRUCT_TINY = 8'hB0;
   localparam logic [7:0] MK_BYTES_8 = 8'hCC;
   localparam logic [7:0] MK_STRING_8 = 8'hD0;
   localparam logic [7:0] MK_LIST_8 = 8'hD4;
   localparam logic [7:0] MK_DICT_8 = 8'hD8;
   localparam logic [7:0] MK_NO_TINY = 8'h00;

   typedef enum logic [3:0] {
      MODE_NULL    = 4'd0,
      MODE_BOOL    = 4'd1,
      MODE_INT     = 4'd2,
      MODE_FLOAT   = 4'd3,
      MODE_STRING  = 4'd4,
      MODE_BYTES   = 4'd5,
      MODE_LIST    = 4'd6,
      MODE_DICT    = 4'd7,
      MODE_STRUCT  = 4'd8,
      MODE_PAYLOAD = 4'd9
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   // one queued job: a left-aligned byte group or a single status result
   typedef struct packed {
      logic [GROUP_W-1:0] bytes;
      logic [LEN_W-1:0]   len;
      logic               byte_valid;
      status_type         status;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

endpackage

// File: sv/pste_queue.sv
`timescale 1ns / 1ps

module pste_queue (
   input  logic                clock,
   input  logic                reset,
   input  pste_pkg::push_type  wr,
   input  logic                pop,
   output pste_pkg::qstat_type stat,
   output pste_pkg::job_type   head
);

   pste_pkg::job_type slot_ff [pste_pkg::QUEUE_DEPTH];

   logic [pste_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pste_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pste_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   always_comb begin
      do_pop = pop && (count_ff != '0);
      do_push = wr.push && (count_ff != pste_pkg::QCNT_W'(pste_pkg::QUEUE_DEPTH));
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == pste_pkg::QPTR_W'(pste_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pste_pkg::QPTR_W'(pste_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + pste_pkg::QCNT_W'(do_push) - pste_pkg::QCNT_W'(do_pop);
   end

   assign stat.full = (count_ff == pste_pkg::QCNT_W'(pste_pkg::QUEUE_DEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign head = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr.job;
      end
   end

endmodule

// File: sv/pste_front.sv
`timescale 1ns / 1ps

module pste_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [3:0]          req_mode,
   input  logic [63:0]         req_value,
   input  logic [7:0]          req_signature,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   input  pste_pkg::qstat_type qstat,
   output pste_pkg::push_type  wr
);

   typedef struct packed {
      logic [pste_pkg::GROUP_W-1:0] bytes;
      logic [pste_pkg::LEN_W-1:0]   len;
   } group_type;

   function automatic group_type size_header(input logic [31:0] n, input logic tiny_en,
                                             input logic [7:0] tiny, input logic [7:0] m8);
      group_type g;
      if (tiny_en && (n[31:4] == '0)) begin
         g.bytes = {tiny | {4'h0, n[3:0]}, 64'h0};
         g.len = 4'd1;
      end else if (n[31:8] == '0) begin
         g.bytes = {m8, n[7:0], 56'h0};
         g.len = 4'd2;
      end else if (n[31:16] == '0) begin
         g.bytes = {m8 + 8'd1, n[15:0], 48'h0};
         g.len = 4'd3;
      end else begin
         g.bytes = {m8 + 8'd2, n, 32'h0};
         g.len = 4'd5;
      end
      return g;
   endfunction

   logic [31:0] room_ff, room_in;
   logic [31:0] written_ff, written_in;
   logic [31:0] pay_left_ff, pay_left_in;
   logic        pay_started_ff, pay_started_in;
   logic        pay_rejected_ff, pay_rejected_in;

   pste_pkg::mode_type mode;
   group_type          grp;
   logic               accept;
   logic               int_tiny, int_8, int_16, int_32;
   logic               over_limit, grp_fits, pay_over;
   logic [31:0]        sat_len;
   logic               emit, ovf, tl;

   assign req_stall = qstat.full;

   always_comb begin
      accept = req_valid && !req_stall;
      mode = pste_pkg::mode_type'(req_mode);

      // sign-extension checks pick the shortest int form
      int_tiny = (~|req_value[63:7]) || (&req_value[63:4]);
      int_8 = (~|req_value[63:7]) || (&req_value[63:7]);
      int_16 = (~|req_value[63:15]) || (&req_value[63:15]);
      int_32 = (~|req_value[63:31]) || (&req_value[63:31]);
      sat_len = (|req_value[63:32]) ? '1 : req_value[31:0];

      grp = '0;
      over_limit = 1'b0;
      case (mode)
         pste_pkg::MODE_NULL: begin
            grp.bytes = {pste_pkg::MK_NULL, 64'h0};
            grp.len = 4'd1;
         end
         pste_pkg::MODE_BOOL: begin
            grp.bytes = {req_value[0] ? pste_pkg::MK_TRUE : pste_pkg::MK_FALSE, 64'h0};
            grp.len = 4'd1;
         end
         pste_pkg::MODE_INT: begin
            if (int_tiny) begin
               grp.bytes = {req_value[7:0], 64'h0};
               grp.len = 4'd1;
            end else if (int_8) begin
               grp.bytes = {pste_pkg::MK_INT8, req_value[7:0], 56'h0};
               grp.len = 4'd2;
            end else if (int_16) begin
               grp.bytes = {pste_pkg::MK_INT16, req_value[15:0], 48'h0};
               grp.len = 4'd3;
            end else if (int_32) begin
               grp.bytes = {pste_pkg::MK_INT32, req_value[31:0], 32'h0};
               grp.len = 4'd5;
            end else begin
               grp.bytes = {pste_pkg::MK_INT64, req_value};
               grp.len = 4'd9;
            end
         end
         pste_pkg::MODE_FLOAT: begin
            grp.bytes = {pste_pkg::MK_FLOAT, req_value};
            grp.len = 4'd9;
         end
         pste_pkg::MODE_STRING: begin
            grp = size_header(req_value[31:0], 1'b1, pste_pkg::MK_STRING_TINY,
                              pste_pkg::MK_STRING_8);
            over_limit = req_value > pste_pkg::MAX_STRING_BYTES;
         end
         pste_pkg::MODE_BYTES: begin
            grp = size_header(req_value[31:0], 1'b0, pste_pkg::MK_NO_TINY,
                              pste_pkg::MK_BYTES_8);
            over_limit = req_value > pste_pkg::MAX_STRING_BYTES;
         end
         pste_pkg::MODE_LIST: begin
            grp = size_header(req_value[31:0], 1'b1, pste_pkg::MK_LIST_TINY,
                              pste_pkg::MK_LIST_8);
            over_limit = req_value > pste_pkg::MAX_ELEMENTS;
         end
         pste_pkg::MODE_DICT: begin
            grp = size_header(req_value[31:0], 1'b1, pste_pkg::MK_DICT_TINY,
                              pste_pkg::MK_DICT_8);
            over_limit = req_value > pste_pkg::MAX_ELEMENTS;
         end
         pste_pkg::MODE_STRUCT: begin
            grp.bytes = {pste_pkg::MK_STRUCT_TINY | {4'h0, req_value[3:0]}, req_signature,
                         56'h0};
            grp.len = 4'd2;
            over_limit = req_value > pste_pkg::MAX_STRUCT_FIELDS;
         end
         pste_pkg::MODE_PAYLOAD: begin
            grp.bytes = {req_value[7:0], 64'h0};
            grp.len = 4'd1;
         end
         default: begin
         end
      endcase

      grp_fits = {28'h0, grp.len} <= room_ff;
      pay_over = pay_left_ff > room_ff;

      room_in = room_ff;
      written_in = written_ff;
      pay_left_in = pay_left_ff;
      pay_started_in = pay_started_ff;
      pay_rejected_in = pay_rejected_ff;
      emit = 1'b0;
      ovf = 1'b0;
      tl = 1'b0;

      if (accept) begin
         case (mode)
            pste_pkg::MODE_PAYLOAD: begin
               if (pay_left_ff == '0) begin
                  // stray byte, no payload pending
                  if (grp_fits) emit = 1'b1;
                  else ovf = 1'b1;
               end else begin
                  if (!pay_started_ff) begin
                     // whole declared payload checked on its first byte
                     pay_started_in = 1'b1;
                     if (pay_over) begin
                        ovf = 1'b1;
                        pay_rejected_in = 1'b1;
                     end else begin
                        emit = 1'b1;
                     end
                  end else if (!pay_rejected_ff) begin
                     if (grp_fits) begin
                        emit = 1'b1;
                     end else begin
                        ovf = 1'b1;
                        pay_rejected_in = 1'b1;
                     end
                  end
                  pay_left_in = pay_left_ff - 32'd1;
                  if (pay_left_ff == 32'd1) begin
                     pay_started_in = 1'b0;
                     pay_rejected_in = 1'b0;
                  end
               end
            end
            pste_pkg::MODE_NULL, pste_pkg::MODE_BOOL, pste_pkg::MODE_INT,
            pste_pkg::MODE_FLOAT, pste_pkg::MODE_STRING, pste_pkg::MODE_BYTES,
            pste_pkg::MODE_LIST, pste_pkg::MODE_DICT, pste_pkg::MODE_STRUCT: begin
               pay_left_in = '0;
               pay_started_in = 1'b0;
               pay_rejected_in = 1'b0;
               if (over_limit) tl = 1'b1;
               else if (grp_fits) emit = 1'b1;
               else ovf = 1'b1;
               if (mode == pste_pkg::MODE_STRING || mode == pste_pkg::MODE_BYTES) begin
                  if (emit) begin
                     pay_left_in = req_value[31:0];
                  end else begin
                     // failed header: its payload is dropped as it arrives
                     pay_left_in = sat_len;
                     pay_started_in = (sat_len != '0);
                     pay_rejected_in = (sat_len != '0);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      wr = '0;
      if (emit) begin
         room_in = room_ff - {28'h0, grp.len};
         written_in = written_ff + {28'h0, grp.len};
         wr.push = 1'b1;
         wr.job.bytes = grp.bytes;
         wr.job.len = grp.len;
         wr.job.byte_valid = 1'b1;
         wr.job.status = pste_pkg::ST_OK;
      end else if (ovf || tl) begin
         wr.push = 1'b1;
         wr.job.len = 4'd1;
         wr.job.byte_valid = 1'b0;
         wr.job.status = tl ? pste_pkg::ST_TOO_LARGE : pste_pkg::ST_OVERFLOW;
      end

      if (csr_wr_en) begin
         room_in = (csr_wr_data > written_ff) ? csr_wr_data - written_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         room_ff <= pste_pkg::RESET_CAPACITY;
         written_ff <= '0;
         pay_left_ff <= '0;
         pay_started_ff <= 1'b0;
         pay_rejected_ff <= 1'b0;
      end else begin
         room_ff <= room_in;
         written_ff <= written_in;
         pay_left_ff <= pay_left_in;
         pay_started_ff <= pay_started_in;
         pay_rejected_ff <= pay_rejected_in;
      end
   end

endmodule

// File: sv/pste_back.sv
`timescale 1ns / 1ps

module pste_back (
   input  logic                clock,
   input  logic                reset,
   input  pste_pkg::qstat_type qstat,
   input  pste_pkg::job_type   head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);

   logic                         active_ff, active_in;
   logic [pste_pkg::GROUP_W-1:0] data_ff, data_in;
   logic [pste_pkg::LEN_W-1:0]   left_ff, left_in;
   logic                         bvalid_ff, bvalid_in;
   pste_pkg::status_type         status_ff, status_in;
   logic                         fire, done;

   always_comb begin
      fire = active_ff && !rsp_stall;
      done = !active_ff || (fire && (left_ff == pste_pkg::LEN_W'(1)));
      pop = done && qstat.not_empty;

      active_in = active_ff;
      data_in = data_ff;
      left_in = left_ff;
      bvalid_in = bvalid_ff;
      status_in = status_ff;
      if (pop) begin
         active_in = 1'b1;
         data_in = head.bytes;
         left_in = head.len;
         bvalid_in = head.byte_valid;
         status_in = head.status;
      end else if (done) begin
         active_in = 1'b0;
      end else if (fire) begin
         data_in = {data_ff[pste_pkg::GROUP_W-9:0], 8'h00};
         left_in = left_ff - 1'b1;
      end
   end

   assign rsp_valid = active_ff;
   assign rsp_out_byte = data_ff[pste_pkg::GROUP_W-1 -: 8];
   assign rsp_byte_valid = bvalid_ff;
   assign rsp_status = status_ff;
   assign rsp_last = (left_ff == pste_pkg::LEN_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      left_ff <= left_in;
      bvalid_ff <= bvalid_in;
      status_ff <= status_in;
   end

endmodule

// File: sv/packstream_token_encoder_unit.sv
`timescale 1ns / 1ps

// Token encoder: one token per req transaction, its wire bytes one per rsp transaction.
// req channel: req_mode selects the token kind, req_value carries the int, float bits,
// length, field count or payload byte, req_signature the struct signature.
// rsp channel: rsp_out_byte with rsp_byte_valid high, or a status-only result
// (rsp_byte_valid low, rsp_status size limit exceeded or overflow); rsp_last marks the
// final result of a token. Tokens that give no result (dropped payload bytes, unknown
// modes) produce no rsp transaction at all.
// csr_wr_en/csr_wr_data set the output byte capacity; write only while idle.
// With the serialiser free, an accepted token is written into the queue and then loaded
// into the serialiser registers, which show its first result.
// Throughput: one result per cycle from the byte serialiser while rsp_stall is low; the
// front classifies one token per cycle into a four-entry queue while it is not full
// and takes new tokens while earlier ones are still being sent.
// Reset (synchronous, active high): capacity 65536, byte count and payload
// tracking cleared, queue emptied, no result shown.
// When rsp_stall is high the shown result holds; once the queue fills, req_stall rises.
module packstream_token_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_mode,
   input  logic [63:0] req_value,
   input  logic [7:0]  req_signature,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   pste_pkg::push_type  wr;
   pste_pkg::qstat_type qstat;
   pste_pkg::job_type   head;
   logic                pop;

   pste_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .req_signature (req_signature),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .qstat         (qstat),
      .wr            (wr)
   );

   pste_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .pop   (pop),
      .stat  (qstat),
      .head  (head)
   );

   pste_back u_back (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

// File: sv/pste_checker.sv
`timescale 1ns / 1ps

`include "packstream_token_encoder_unit_defines.svh"

module pste_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);

   // a stalled result keeps its contents
   `PSTE_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_byte_valid) && $stable(rsp_status) && $stable(rsp_last)))

   // a status result stands alone as the last of its token and carries no byte
   `PSTE_ASSERT(a_status_alone, (rsp_valid && rsp_status != pste_pkg::ST_OK |-> !rsp_byte_valid && rsp_last && rsp_out_byte == 8'h00))

   // byte results are ok, status results are not
   `PSTE_ASSERT(a_byte_status, (rsp_valid |-> rsp_byte_valid == (rsp_status == pste_pkg::ST_OK)))

   // reset empties both sides
   `PSTE_ASSERT_RST(a_reset_idle, (reset |=> !rsp_valid && !req_stall))

endmodule

bind packstream_token_encoder_unit pste_checker u_pste_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_status     (rsp_status),
   .rsp_last       (rsp_last)
);

// File: tb/sv/packstream_token_encoder_unit_tb.sv
`timescale 1ns / 1ps

module packstream_token_encoder_unit_tb;
   import pste_pkg::*;

   localparam logic [3:0] MODE_UNUSED_LO = 4'd10;
   localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

   typedef struct {
      logic [7:0] data;
      logic       has_byte;
      status_type status;
      logic       last;
   } enc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_mode = 4'd0;
   logic [63:0] req_value = 64'd0;
   logic [7:0]  req_signature = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic [1:0]  rsp_status;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'd0;

   // encoder state as the block should hold it
   logic [31:0] byte_budget = RESET_CAPACITY;
   logic [31:0] bytes_sent = 32'd0;
   logic        overflow_seen = 1'b0;
   logic [31:0] payload_due = 32'd0;
   logic        payload_begun = 1'b0;
   logic        payload_dropping = 1'b0;

   enc_result_type pending_results[$];
   int unsigned error_count = 0;
   bit          steady_flow = 1'b0;

   packstream_token_encoder_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .req_signature  (req_signature),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= !steady_flow && ($urandom_range(0, 99) < 26);
   end

   function automatic logic [31:0] room_left();
      return (byte_budget > bytes_sent) ? byte_budget - bytes_sent : 32'd0;
   endfunction

   task automatic push_status(input status_type st);
      enc_result_type r;
      r.data = 8'h00;
      r.has_byte = 1'b0;
      r.status = st;
      r.last = 1'b1;
      pending_results.push_back(r);
      if (st == ST_OVERFLOW) overflow_seen = 1'b1;
   endtask

   // grp holds the group left-aligned, n bytes long
   task automatic emit_group(input logic [71:0] grp, input int unsigned n, output bit fitted);
      enc_result_type r;
      fitted = (n <= room_left());
      if (!fitted) begin
         push_status(ST_OVERFLOW);
      end else begin
         for (int k = 0; k < n; k++) begin
            r.data = grp[71 - 8*k -: 8];
            r.has_byte = 1'b1;
            r.status = ST_OK;
            r.last = (k == n - 1);
            pending_results.push_back(r);
         end
         bytes_sent += n;
      end
   endtask

   function automatic int unsigned int_form(input logic [63:0] u, output logic [71:0] grp);
      if (~|u[63:7] || &u[63:4]) begin
         grp = {u[7:0], 64'd0};
         return 1;
      end
      if (&u[63:7]) begin
         grp = {MK_INT8, u[7:0], 56'd0};
         return 2;
      end
      if (~|u[63:15] || &u[63:15]) begin
         grp = {MK_INT16, u[15:0], 48'd0};
         return 3;
      end
      if (~|u[63:31] || &u[63:31]) begin
         grp = {MK_INT32, u[31:0], 32'd0};
         return 5;
      end
      grp = {MK_INT64, u};
      return 9;
   endfunction

   function automatic int unsigned size_header(input logic [31:0] n, input logic [7:0] tiny,
         input logic [7:0] mark8, output logic [71:0] grp);
      if (tiny != MK_NO_TINY && n <= 32'd15) begin
         grp = {tiny | n[7:0], 64'd0};
         return 1;
      end
      if (n <= 32'hFF) begin
         grp = {mark8, n[7:0], 56'd0};
         return 2;
      end
      if (n <= 32'hFFFF) begin
         grp = {mark8 + 8'd1, n[15:0], 48'd0};
         return 3;
      end
      grp = {mark8 + 8'd2, n, 32'd0};
      return 5;
   endfunction

   task automatic forget_payload();
      payload_due = 32'd0;
      payload_begun = 1'b0;
      payload_dropping = 1'b0;
   endtask

   task automatic encode_payload_byte(input logic [7:0] b);
      bit fitted;
      if (payload_due == 32'd0) begin
         emit_group({b, 64'd0}, 1, fitted);
      end else begin
         if (!payload_begun) begin
            // the whole declared payload must fit on its first byte
            payload_begun = 1'b1;
            if (payload_due > room_left()) begin
               payload_dropping = 1'b1;
               push_status(ST_OVERFLOW);
            end else begin
               emit_group({b, 64'd0}, 1, fitted);
            end
         end else if (!payload_dropping) begin
            emit_group({b, 64'd0}, 1, fitted);
            if (!fitted) payload_dropping = 1'b1;
         end
         payload_due--;
         if (payload_due == 32'd0) forget_payload();
      end
   endtask

   task automatic encode_token(input logic [3:0] mode, input logic [63:0] value,
         input logic [7:0] sig);
      logic [71:0] grp;
      int unsigned n;
      bit fitted;
      if (mode == MODE_PAYLOAD) begin
         encode_payload_byte(value[7:0]);
      end else if (mode < MODE_PAYLOAD) begin
         forget_payload();
         case (mode)
            MODE_NULL: emit_group({MK_NULL, 64'd0}, 1, fitted);
            MODE_BOOL: emit_group({(value[0] ? MK_TRUE : MK_FALSE), 64'd0}, 1, fitted);
            MODE_INT: begin
               n = int_form(value, grp);
               emit_group(grp, n, fitted);
            end
            MODE_FLOAT: emit_group({MK_FLOAT, value}, 9, fitted);
            MODE_STRING, MODE_BYTES: begin
               fitted = 1'b0;
               if (value > MAX_STRING_BYTES) begin
                  push_status(ST_TOO_LARGE);
               end else begin
                  if (mode == MODE_STRING)
                     n = size_header(value[31:0], MK_STRING_TINY, MK_STRING_8, grp);
                  else
                     n = size_header(value[31:0], MK_NO_TINY, MK_BYTES_8, grp);
                  emit_group(grp, n, fitted);
               end
               if (fitted) begin
                  payload_due = value[31:0];
               end else begin
                  // a refused header drops its payload silently
                  payload_due = (|value[63:32]) ? 32'hFFFF_FFFF : value[31:0];
                  if (payload_due != 32'd0) begin
                     payload_begun = 1'b1;
                     payload_dropping = 1'b1;
                  end
               end
            end
            MODE_LIST, MODE_DICT: begin
               if (value > MAX_ELEMENTS) begin
                  push_status(ST_TOO_LARGE);
               end else begin
                  if (mode == MODE_LIST)
                     n = size_header(value[31:0], MK_LIST_TINY, MK_LIST_8, grp);
                  else
                     n = size_header(value[31:0], MK_DICT_TINY, MK_DICT_8, grp);
                  emit_group(grp, n, fitted);
               end
            end
            MODE_STRUCT: begin
               if (value > MAX_STRUCT_FIELDS)
                  push_status(ST_TOO_LARGE);
               else
                  emit_group({MK_STRUCT_TINY | value[7:0], sig, 56'd0}, 2, fitted);
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin : check_rsp
      enc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: out_byte %02h byte_valid %0d status %0d",
                   rsp_out_byte, rsp_byte_valid, rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %02h, actual %02h", want.data, rsp_out_byte);
               error_count++;
            end
            if (rsp_byte_valid !== want.has_byte) begin
               $error("byte_valid: expected %0d, actual %0d", want.has_byte, rsp_byte_valid);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // called at a falling edge; valid stays high for a following transaction
   task automatic put_token(input logic [3:0] mode, input logic [63:0] value,
         input logic [7:0] sig);
      while (!steady_flow && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_value <= value;
      req_signature <= sig;
      do @(posedge clock); while (req_stall);
      encode_token(mode, value, sig);
      @(negedge clock);
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      // dropped bytes give no result but may still be in flight
      repeat (16) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [31:0] cap);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      byte_budget = cap;
      @(negedge clock);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // ints spread over every width, with the form boundaries hit often
   function automatic logic [63:0] random_int();
      logic [63:0] v;
      int unsigned b;
      if ($urandom_range(0, 1)) begin
         v = random_word();
         return $signed(v) >>> $urandom_range(0, 63);
      end
      case ($urandom_range(0, 4))
         0: b = 4;
         1: b = 7;
         2: b = 15;
         3: b = 31;
         default: b = 63;
      endcase
      v = (64'd1 << b) + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   function automatic logic [63:0] boundary_length();
      case ($urandom_range(0, 9))
         0: return 64'd0 + $urandom_range(0, 15);
         1: return 64'd15 + $urandom_range(0, 1);
         2: return 64'd255 + $urandom_range(0, 1);
         3: return 64'd65535 + $urandom_range(0, 1);
         4: return MAX_ELEMENTS - 1 + $urandom_range(0, 2);
         5: return MAX_STRING_BYTES - 1 + $urandom_range(0, 2);
         6: return random_word();
         7: return 64'hFFFF_FFFF + $urandom_range(0, 1);
         default: return 64'd0 + $urandom_range(0, 1000);
      endcase
   endfunction

   task automatic send_random_sequence(inout int unsigned sent);
      int unsigned pick;
      int unsigned len;
      int unsigned count;
      logic [3:0] m;
      logic [63:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         m = 4'($urandom_range(MODE_NULL, MODE_FLOAT));
         v = (m == MODE_INT) ? random_int() : random_word();
         put_token(m, v, 8'($urandom_range(0, 255)));
         sent += 1;
      end else if (pick < 65) begin
         // string or bytes header followed by its payload, now and then cut short
         m = $urandom_range(0, 1) ? MODE_STRING : MODE_BYTES;
         case ($urandom_range(0, 29))
            0: len = $urandom_range(16, 300);
            1: len = 32'hFFFF + $urandom_range(0, 1);
            2: len = MAX_STRING_BYTES[31:0] - $urandom_range(0, 1);
            default: len = $urandom_range(0, 15);
         endcase
         count = len;
         if (len > 300)
            count = $urandom_range(0, 24);
         else if ($urandom_range(0, 6) == 0)
            count = $urandom_range(0, len);
         put_token(m, {32'd0, len}, 8'($urandom_range(0, 255)));
         repeat (count) put_token(MODE_PAYLOAD, random_word(), 8'($urandom_range(0, 255)));
         sent += 1 + count;
      end else if (pick < 85) begin
         m = 4'($urandom_range(MODE_LIST, MODE_STRUCT));
         v = (m == MODE_STRUCT) ? 64'd0 + $urandom_range(0, 17) : boundary_length();
         put_token(m, v, 8'($urandom_range(0, 255)));
         sent += 1;
      end else if (pick < 92) begin
         put_token(MODE_PAYLOAD, random_word(), 8'($urandom_range(0, 255)));
         sent += 1;
      end else if (pick < 96) begin
         put_token(4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), random_word(),
                   8'($urandom_range(0, 255)));
      end else begin
         // oversized header, its payload bytes vanish
         m = $urandom_range(0, 1) ? MODE_STRING : MODE_BYTES;
         v = random_word() | (64'd1 << $urandom_range(25, 63));
         put_token(m, v, 8'($urandom_range(0, 255)));
         repeat ($urandom_range(0, 3))
            put_token(MODE_PAYLOAD, random_word(), 8'($urandom_range(0, 255)));
         sent += 1;
      end
   endtask

   task automatic run_random_traffic(input int unsigned n_items);
      int unsigned sent;
      sent = 0;
      while (sent < n_items) begin
         send_random_sequence(sent);
         if ($urandom_range(0, 39) == 0) wait_results_done();
      end
   endtask

   task automatic test_scalar_tokens();
      put_token(MODE_NULL, random_word(), 8'h00);
      put_token(MODE_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, 8'hFF);
      put_token(MODE_BOOL, 64'h0000_0000_0000_0001, 8'h00);
      put_token(MODE_INT, 64'd127, 8'h00);
      put_token(MODE_INT, 64'hFFFF_FFFF_FFFF_FFF0, 8'h00);
      put_token(MODE_INT, 64'hFFFF_FFFF_FFFF_FFEF, 8'h00);
      put_token(MODE_INT, 64'd128, 8'h00);
      put_token(MODE_INT, 64'hFFFF_FFFF_FFFF_7FFF, 8'h00);
      put_token(MODE_INT, 64'h0000_0000_8000_0000, 8'h00);
      put_token(MODE_INT, 64'h8000_0000_0000_0000, 8'h00);
      put_token(MODE_FLOAT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
   endtask

   task automatic test_size_headers();
      put_token(MODE_STRING, 64'd15, 8'h00);
      put_token(MODE_BYTES, 64'd0, 8'h00);
      put_token(MODE_LIST, 64'd16, 8'h00);
      put_token(MODE_DICT, 64'd65535, 8'h00);
      put_token(MODE_STRING, 64'd65536, 8'h00);
      put_token(MODE_STRUCT, 64'd15, 8'hA5);
      put_token(MODE_STRUCT, 64'd16, 8'h5A);
      put_token(MODE_LIST, MAX_ELEMENTS + 1, 8'h00);
      put_token(MODE_DICT, MAX_ELEMENTS, 8'h00);
      put_token(MODE_BYTES, MAX_STRING_BYTES, 8'h00);
      put_token(MODE_STRING, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
   endtask

   task automatic test_payloads();
      put_token(MODE_STRING, 64'd3, 8'h00);
      repeat (3) put_token(MODE_PAYLOAD, random_word(), 8'h00);
      put_token(MODE_PAYLOAD, 64'h0000_0000_0000_00FF, 8'h00);
      put_token(MODE_BYTES, 64'd4, 8'h00);
      put_token(MODE_PAYLOAD, random_word(), 8'h00);
      // unused modes leave the pending payload alone
      put_token(MODE_UNUSED_HI, random_word(), 8'hFF);
      put_token(MODE_PAYLOAD, random_word(), 8'h00);
      put_token(MODE_NULL, 64'd0, 8'h00);
      put_token(MODE_PAYLOAD, 64'd0, 8'h00);
   endtask

   task automatic test_capacity_limits();
      wait_results_done();
      set_capacity(32'd0);
      put_token(MODE_NULL, 64'd0, 8'h00);
      put_token(MODE_STRING, 64'd2, 8'h00);
      repeat (2) put_token(MODE_PAYLOAD, random_word(), 8'h00);
      wait_results_done();
      // header fits but the payload as a whole does not
      set_capacity(bytes_sent + 32'd4);
      put_token(MODE_STRING, 64'd5, 8'h00);
      repeat (2) put_token(MODE_PAYLOAD, random_word(), 8'h00);
      put_token(MODE_INT, 64'd1, 8'h00);
      wait_results_done();
      set_capacity(bytes_sent + 32'd10);
      put_token(MODE_BYTES, 64'd3, 8'h00);
      put_token(MODE_PAYLOAD, random_word(), 8'h00);
      // lowered mid-payload, so the last byte runs out of room
      wait_results_done();
      set_capacity(bytes_sent + 32'd1);
      repeat (2) put_token(MODE_PAYLOAD, random_word(), 8'h00);
      wait_results_done();
      set_capacity(32'hFFFF_FFFF);
      put_token(MODE_FLOAT, random_word(), 8'h00);
   endtask

   task automatic test_random_mixed();
      run_random_traffic(200);
   endtask

   task automatic test_random_steady();
      wait_results_done();
      steady_flow = 1'b1;
      run_random_traffic(100);
      wait_results_done();
      steady_flow = 1'b0;
   endtask

   task automatic test_random_tight_capacity();
      logic [31:0] cap;
      repeat (5) begin
         wait_results_done();
         if ($urandom_range(0, 3) == 0 && bytes_sent > 32'd10)
            cap = bytes_sent - $urandom_range(0, 10);
         else
            cap = bytes_sent + $urandom_range(0, 120);
         set_capacity(cap);
         run_random_traffic(30);
      end
   endtask

   task automatic test_random_open_capacity();
      wait_results_done();
      set_capacity($urandom | 32'h8000_0000);
      run_random_traffic(50);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_scalar_tokens();
      test_size_headers();
      test_payloads();
      test_capacity_limits();
      test_random_mixed();
      test_random_steady();
      test_random_tight_capacity();
      test_random_open_capacity();
      wait_results_done();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/pste_pkg.sv
sv/pste_queue.sv
sv/pste_front.sv
sv/pste_back.sv
sv/packstream_token_encoder_unit.sv
sv/pste_checker.sv
tb/sv/packstream_token_encoder_unit_tb.sv
